### design/bracket_quote_comment_checker_defines.svh
// Assertion macros for the bracket, quote and comment checker.
// Used by the top level; needs clk_i and rst_ni in the enclosing module.
`ifndef BRACKET_QUOTE_COMMENT_CHECKER_DEFINES_SVH
`define BRACKET_QUOTE_COMMENT_CHECKER_DEFINES_SVH

`ifndef SYNTH
`define BQC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bqc assertion failed");
`define BQC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bqc assertion failed");
`else
`define BQC_ASSERT_SAME(label, ante, cons)
`define BQC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### design/bqc_pkg.sv
// Package for the bracket, quote and comment checker.
// Holds the character constants, mode and result codes and stack sizing.
package bqc_pkg;

  localparam int unsigned STACK_DEPTH = 1024;
  localparam int unsigned DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
  localparam int unsigned COUNT_MAX = 2047;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam logic [1:0] BR_PAREN = 2'd0;
  localparam logic [1:0] BR_BRACK = 2'd1;
  localparam logic [1:0] BR_BRACE = 2'd2;

  typedef enum logic [1:0] {
    MODE_CODE    = 2'd0,
    MODE_COMMENT = 2'd1,
    MODE_SQ      = 2'd2,
    MODE_DQ      = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_NOOPEN   = 2'd1,
    EV_MISMATCH = 2'd2,
    EV_OVERFLOW = 2'd3
  } ev_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_COMMENT  = 3'd1,
    ST_SQ       = 3'd2,
    ST_DQ       = 3'd3,
    ST_UNCLOSED = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_e;

  function automatic logic [7:0] opener_char(input logic [1:0] code);
    logic [7:0] c;
    case (code)
      BR_PAREN: c = CH_LPAREN;
      BR_BRACK: c = CH_LBRACK;
      default:  c = CH_LBRACE;
    endcase
    return c;
  endfunction

endpackage

### design/bqc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Read during a write to the same address returns the old contents.
module bqc_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/bracket_quote_comment_checker.sv
// Each byte is held in an input register and its result in an output register.
// Throughput: one byte per cycle unless out_ready_i stalls the output; the bracket
// stack top sits in a register and the entry below is prefetched from the stack RAM,
// so a push or pop never waits. Reset clears mode, flags, depth and line count (line
// count restarts at one). The stack RAM is not cleared; only entries below the current depth are used.
// Top level of the bracket, quote and comment checker; uses bqc_pkg, bqc_ram
// and the assertion macros in bracket_quote_comment_checker_defines.svh.
`include "bracket_quote_comment_checker_defines.svh"

module bracket_quote_comment_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ch_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  event_res_o,
  output logic [31:0] line_number_o,
  output logic [7:0]  closing_char_o,
  output logic [7:0]  opening_char_o,
  output logic        final_valid_o,
  output logic [2:0]  final_status_o,
  output logic [10:0] unclosed_count_o
);
  import bqc_pkg::*;

  logic              in_v_q;
  logic [7:0]        ch_q;
  logic              last_q;
  logic              out_v_q;
  logic              adv;
  logic              fire;

  mode_e             mode_q, mode_d;
  logic              la_q, la_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [1:0]        tos_q, tos_d;
  logic [31:0]       line_q, line_d;
  logic              err_q, err_d;
  logic              halt_q, halt_d;
  logic              byp_q, byp_d;
  logic [1:0]        byp_data_q;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [1:0]        rdata;
  logic [1:0]        below;
  logic [1:0]        top;

  ev_e               ev_d, ev_q;
  logic [7:0]        cl_d, cl_q;
  logic [7:0]        op_d, op_q;
  status_e           fst_d, fst_q;
  logic [10:0]       cnt_d, cnt_q;
  logic              fv_q;
  logic [31:0]       line_num_q;

  logic              fresh;
  logic              is_open, is_close;
  logic [1:0]        oc, cc;

  assign adv        = !out_v_q || out_ready_i;
  assign fire       = in_v_q && adv;
  assign in_ready_o = !in_v_q || adv;
  assign below      = byp_q ? byp_data_q : rdata;
  assign top        = (tos_q == 2'd3) ? BR_BRACE : tos_q;

  always_comb begin
    is_open  = 1'b1;
    oc       = BR_PAREN;
    is_close = 1'b1;
    cc       = BR_PAREN;
    unique case (ch_q)
      CH_LPAREN: oc = BR_PAREN;
      CH_LBRACK: oc = BR_BRACK;
      CH_LBRACE: oc = BR_BRACE;
      default:   is_open = 1'b0;
    endcase
    unique case (ch_q)
      CH_RPAREN: cc = BR_PAREN;
      CH_RBRACK: cc = BR_BRACK;
      CH_RBRACE: cc = BR_BRACE;
      default:   is_close = 1'b0;
    endcase
  end

  always_comb begin
    mode_d  = mode_q;
    la_d    = la_q;
    depth_d = depth_q;
    tos_d   = tos_q;
    line_d  = line_q;
    err_d   = err_q;
    halt_d  = halt_q;
    byp_d   = 1'b0;
    we      = 1'b0;
    waddr   = ADDR_W'(depth_q - DEPTH_W'(1));
    ev_d    = EV_NONE;
    cl_d    = 8'd0;
    op_d    = 8'd0;
    fresh   = 1'b1;

    if (fire && !halt_q) begin
      if (ch_q == CH_NEWLINE && line_q != 32'hFFFF_FFFF) begin
        line_d = line_q + 32'd1;
      end

      if (la_q) begin
        la_d = 1'b0;
        unique case (mode_q)
          MODE_CODE: begin
            if (ch_q == CH_STAR) begin
              mode_d = MODE_COMMENT;
              fresh  = 1'b0;
            end
          end
          MODE_COMMENT: begin
            if (ch_q == CH_SLASH) begin
              mode_d = MODE_CODE;
              fresh  = 1'b0;
            end
          end
          MODE_SQ, MODE_DQ: fresh = 1'b0;
        endcase
      end

      if (fresh) begin
        unique case (mode_q)
          MODE_CODE: begin
            if (ch_q == CH_SQUOTE) begin
              mode_d = MODE_SQ;
            end else if (ch_q == CH_DQUOTE) begin
              mode_d = MODE_DQ;
            end else if (ch_q == CH_SLASH) begin
              la_d = 1'b1;
            end else if (is_open) begin
              if (depth_q < DEPTH_W'(STACK_DEPTH)) begin
                we      = depth_q != '0;
                tos_d   = oc;
                depth_d = depth_q + DEPTH_W'(1);
                byp_d   = 1'b1;
              end else begin
                ev_d   = EV_OVERFLOW;
                halt_d = 1'b1;
              end
            end else if (is_close) begin
              if (depth_q == '0) begin
                ev_d  = EV_NOOPEN;
                cl_d  = ch_q;
                err_d = 1'b1;
              end else begin
                depth_d = depth_q - DEPTH_W'(1);
                tos_d   = below;
                if (top != cc) begin
                  ev_d  = EV_MISMATCH;
                  cl_d  = ch_q;
                  op_d  = opener_char(top);
                  err_d = 1'b1;
                end
              end
            end
          end
          MODE_COMMENT: begin
            if (ch_q == CH_STAR) begin
              la_d = 1'b1;
            end
          end
          MODE_SQ, MODE_DQ: begin
            if (ch_q == CH_BSLASH) begin
              la_d = 1'b1;
            end else if ((mode_q == MODE_SQ && ch_q == CH_SQUOTE) ||
                         (mode_q == MODE_DQ && ch_q == CH_DQUOTE)) begin
              mode_d = MODE_CODE;
            end
          end
        endcase
      end
    end

    raddr = ADDR_W'(depth_d - DEPTH_W'(2));
  end

  always_comb begin
    fst_d = ST_OK;
    cnt_d = 11'd0;
    if (last_q) begin
      if (halt_d) begin
        fst_d = ST_OVERFLOW;
      end else if (mode_d == MODE_COMMENT) begin
        fst_d = ST_COMMENT;
      end else if (mode_d == MODE_SQ) begin
        fst_d = ST_SQ;
      end else if (mode_d == MODE_DQ) begin
        fst_d = ST_DQ;
      end else if (depth_d != '0 || err_d) begin
        fst_d = ST_UNCLOSED;
      end
      cnt_d = (32'(depth_d) > COUNT_MAX) ? 11'(COUNT_MAX) : 11'(depth_d);
    end
  end

  bqc_ram #(
    .WIDTH(2),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(tos_q),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      mode_q  <= MODE_CODE;
      la_q    <= 1'b0;
      depth_q <= '0;
      line_q  <= 32'd1;
      err_q   <= 1'b0;
      halt_q  <= 1'b0;
      byp_q   <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_v_q <= in_valid_i;
      end
      if (adv) begin
        out_v_q <= in_v_q;
      end
      mode_q  <= mode_d;
      la_q    <= la_d;
      depth_q <= depth_d;
      line_q  <= line_d;
      err_q   <= err_d;
      halt_q  <= halt_d;
      byp_q   <= byp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ch_q   <= ch_byte_i;
      last_q <= last_i;
    end
    tos_q      <= tos_d;
    byp_data_q <= tos_q;
    if (fire) begin
      ev_q       <= ev_d;
      cl_q       <= cl_d;
      op_q       <= op_d;
      fst_q      <= fst_d;
      cnt_q      <= cnt_d;
      fv_q       <= last_q;
      line_num_q <= line_d;
    end
  end

  assign out_valid_o      = out_v_q;
  assign event_res_o      = ev_q;
  assign line_number_o    = line_num_q;
  assign closing_char_o   = cl_q;
  assign opening_char_o   = op_q;
  assign final_valid_o    = fv_q;
  assign final_status_o   = fst_q;
  assign unclosed_count_o = cnt_q;

  `BQC_ASSERT_NEXT(a_halt_freezes, halt_q, $stable(depth_q) && $stable(line_q) && $stable(mode_q))
  `BQC_ASSERT_SAME(a_ovf_halts, out_v_q && ev_q == EV_OVERFLOW, halt_q)
  `BQC_ASSERT_SAME(a_err_sticky, out_v_q && (ev_q == EV_NOOPEN || ev_q == EV_MISMATCH), err_q)
  `BQC_ASSERT_NEXT(a_push_depth, byp_d, depth_q == $past(depth_q) + DEPTH_W'(1))

endmodule

### bench/tb_bracket_quote_comment_checker.sv
// Testbench for bracket_quote_comment_checker: a directed table, random C-like text and a
// final stack overflow, with every result checked against a predictor or a typed table row.
// Depends on bqc_pkg and the bracket_quote_comment_checker top level.
module tb_bracket_quote_comment_checker;
  import bqc_pkg::*;

  typedef struct packed {
    ev_e         ev;
    logic [31:0] line;
    logic [7:0]  cl;
    logic [7:0]  op;
    logic        fv;
    status_e     st;
    logic [10:0] cnt;
  } scan_result_t;

  typedef struct packed {
    logic [7:0]   ch;
    logic         lst;
    logic         typed;
    scan_result_t res;
  } text_row_t;

  localparam int unsigned N_ROWS = 30;
  localparam int unsigned N_RANDOM = 200;
  localparam int unsigned MAX_NEST = 48;
  localparam scan_result_t NO_RES = '0;
  localparam logic [7:0] OPEN_CH [3] = '{CH_LPAREN, CH_LBRACK, CH_LBRACE};
  localparam logic [7:0] CLOSE_CH [3] = '{CH_RPAREN, CH_RBRACK, CH_RBRACE};

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  ch_byte_i;
  logic        last_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  event_res_o;
  logic [31:0] line_number_o;
  logic [7:0]  closing_char_o;
  logic [7:0]  opening_char_o;
  logic        final_valid_o;
  logic [2:0]  final_status_o;
  logic [10:0] unclosed_count_o;

  bracket_quote_comment_checker dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .ch_byte_i        (ch_byte_i),
    .last_i           (last_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .event_res_o      (event_res_o),
    .line_number_o    (line_number_o),
    .closing_char_o   (closing_char_o),
    .opening_char_o   (opening_char_o),
    .final_valid_o    (final_valid_o),
    .final_status_o   (final_status_o),
    .unclosed_count_o (unclosed_count_o)
  );

  // Scanner state as the predictor sees it.
  mode_e       m_mode;
  logic        m_pending;
  logic [1:0]  m_stack [STACK_DEPTH];
  int unsigned m_depth;
  logic [31:0] m_line;
  logic        m_err;
  logic        m_halted;

  scan_result_t scan_results_q [$];
  int unsigned  bad_results;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  int unsigned  hold_left;

  text_row_t text_rows [N_ROWS] = '{
    '{8'h00, 1'b0, 1'b1, '{EV_NONE, 32'd1, 8'h00, 8'h00, 1'b0, ST_OK, 11'd0}},
    '{CH_LPAREN, 1'b0, 1'b0, NO_RES},
    '{CH_LBRACK, 1'b0, 1'b0, NO_RES},
    '{CH_LBRACE, 1'b0, 1'b0, NO_RES},
    '{CH_RBRACE, 1'b0, 1'b0, NO_RES},
    '{CH_RBRACK, 1'b0, 1'b0, NO_RES},
    '{CH_RPAREN, 1'b0, 1'b0, NO_RES},
    '{CH_NEWLINE, 1'b1, 1'b1, '{EV_NONE, 32'd2, 8'h00, 8'h00, 1'b1, ST_OK, 11'd0}},
    '{CH_SLASH, 1'b1, 1'b0, NO_RES},
    '{CH_STAR, 1'b0, 1'b0, NO_RES},
    '{CH_STAR, 1'b0, 1'b0, NO_RES},
    '{CH_NEWLINE, 1'b1, 1'b0, NO_RES},
    '{CH_STAR, 1'b0, 1'b0, NO_RES},
    '{CH_SLASH, 1'b0, 1'b0, NO_RES},
    '{CH_SLASH, 1'b0, 1'b0, NO_RES},
    '{CH_SLASH, 1'b0, 1'b0, NO_RES},
    '{CH_SQUOTE, 1'b0, 1'b0, NO_RES},
    '{CH_BSLASH, 1'b0, 1'b0, NO_RES},
    '{CH_SQUOTE, 1'b0, 1'b0, NO_RES},
    '{CH_NEWLINE, 1'b1, 1'b0, NO_RES},
    '{CH_SQUOTE, 1'b0, 1'b0, NO_RES},
    '{CH_DQUOTE, 1'b0, 1'b0, NO_RES},
    '{CH_BSLASH, 1'b0, 1'b0, NO_RES},
    '{CH_NEWLINE, 1'b0, 1'b0, NO_RES},
    '{CH_RPAREN, 1'b1, 1'b0, NO_RES},
    '{CH_DQUOTE, 1'b0, 1'b0, NO_RES},
    '{CH_RPAREN, 1'b0, 1'b1, '{EV_NOOPEN, 32'd5, CH_RPAREN, 8'h00, 1'b0, ST_OK, 11'd0}},
    '{CH_LPAREN, 1'b0, 1'b0, NO_RES},
    '{CH_RBRACK, 1'b0, 1'b1, '{EV_MISMATCH, 32'd5, CH_RBRACK, CH_LPAREN, 1'b0, ST_OK, 11'd0}},
    '{8'hFF, 1'b1, 1'b1, '{EV_NONE, 32'd5, 8'h00, 8'h00, 1'b1, ST_UNCLOSED, 11'd0}}
  };

  function automatic int bracket_index(input logic [7:0] b, input logic [7:0] tbl [3]);
    for (int k = 0; k < 3; k++) begin
      if (tbl[k] == b) return k;
    end
    return -1;
  endfunction

  function automatic scan_result_t scan_byte(input logic [7:0] b, input logic lst);
    scan_result_t r;
    logic fresh;
    int oi;
    int ci;
    r = NO_RES;
    oi = bracket_index(b, OPEN_CH);
    ci = bracket_index(b, CLOSE_CH);
    if (!m_halted) begin
      fresh = 1'b1;
      if (b == CH_NEWLINE && m_line != 32'hFFFF_FFFF) m_line++;
      if (m_pending) begin
        m_pending = 1'b0;
        case (m_mode)
          MODE_CODE: begin
            if (b == CH_STAR) begin
              m_mode = MODE_COMMENT;
              fresh = 1'b0;
            end
          end
          MODE_COMMENT: begin
            if (b == CH_SLASH) begin
              m_mode = MODE_CODE;
              fresh = 1'b0;
            end
          end
          default: fresh = 1'b0;
        endcase
      end
      if (fresh) begin
        case (m_mode)
          MODE_CODE: begin
            if (b == CH_SQUOTE) begin
              m_mode = MODE_SQ;
            end else if (b == CH_DQUOTE) begin
              m_mode = MODE_DQ;
            end else if (b == CH_SLASH) begin
              m_pending = 1'b1;
            end else if (oi >= 0) begin
              if (m_depth < STACK_DEPTH) begin
                m_stack[m_depth] = 2'(oi);
                m_depth++;
              end else begin
                r.ev = EV_OVERFLOW;
                m_halted = 1'b1;
              end
            end else if (ci >= 0) begin
              if (m_depth == 0) begin
                r.ev = EV_NOOPEN;
                r.cl = b;
                m_err = 1'b1;
              end else begin
                m_depth--;
                if (m_stack[m_depth] != 2'(ci)) begin
                  r.ev = EV_MISMATCH;
                  r.cl = b;
                  r.op = OPEN_CH[m_stack[m_depth]];
                  m_err = 1'b1;
                end
              end
            end
          end
          MODE_COMMENT: begin
            if (b == CH_STAR) m_pending = 1'b1;
          end
          default: begin
            if (b == CH_BSLASH) begin
              m_pending = 1'b1;
            end else if ((m_mode == MODE_SQ && b == CH_SQUOTE) ||
                         (m_mode == MODE_DQ && b == CH_DQUOTE)) begin
              m_mode = MODE_CODE;
            end
          end
        endcase
      end
    end
    r.line = m_line;
    r.fv = lst;
    if (lst) begin
      if (m_halted) r.st = ST_OVERFLOW;
      else if (m_mode == MODE_COMMENT) r.st = ST_COMMENT;
      else if (m_mode == MODE_SQ) r.st = ST_SQ;
      else if (m_mode == MODE_DQ) r.st = ST_DQ;
      else if (m_depth != 0 || m_err) r.st = ST_UNCLOSED;
      else r.st = ST_OK;
      r.cnt = (m_depth > COUNT_MAX) ? 11'(COUNT_MAX) : 11'(m_depth);
    end
    return r;
  endfunction

  // Mostly well-formed text that follows the scanner's current mode, with some noise.
  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 8'($urandom);
    case (m_mode)
      MODE_CODE: begin
        if (m_pending) return (r < 70) ? CH_STAR : 8'($urandom_range(32, 126));
        if (r < 30 && m_depth < MAX_NEST) return OPEN_CH[$urandom_range(2)];
        if (r < 55 && m_depth > 0) begin
          if (r < 52) return CLOSE_CH[m_stack[m_depth - 1]];
          return CLOSE_CH[$urandom_range(2)];
        end
        if (r < 60) return CH_SQUOTE;
        if (r < 65) return CH_DQUOTE;
        if (r < 69) return CH_SLASH;
        if (r < 76) return CH_NEWLINE;
        if (r < 78) return CLOSE_CH[$urandom_range(2)];
        return 8'($urandom_range(32, 126));
      end
      MODE_COMMENT: begin
        if (m_pending) return (r < 60) ? CH_SLASH : 8'($urandom_range(32, 126));
        if (r < 25) return CH_STAR;
        if (r < 35) return CH_NEWLINE;
        return 8'($urandom_range(32, 126));
      end
      default: begin
        if (m_pending) return (r < 30) ? CH_NEWLINE : 8'($urandom_range(32, 126));
        if (r < 22) return CH_BSLASH;
        if (r < 40) return (m_mode == MODE_SQ) ? CH_SQUOTE : CH_DQUOTE;
        if (r < 48) return CH_NEWLINE;
        return 8'($urandom_range(32, 126));
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic lst, input logic typed,
                           input scan_result_t typed_res);
    scan_result_t r;
    ch_byte_i <= b;
    last_i <= lst;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    r = scan_byte(b, lst);
    scan_results_q.push_back(typed ? typed_res : r);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    scan_result_t want;
    scan_result_t got;
    got = {event_res_o, line_number_o, closing_char_o, opening_char_o,
           final_valid_o, final_status_o, unclosed_count_o};
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (scan_results_q.size() == 0) begin
        if (bad_results < 10) $display("unexpected result: ev=%0d line=%0d", got.ev, got.line);
        bad_results++;
      end else begin
        want = scan_results_q.pop_front();
        if (got !== want) begin
          if (bad_results < 10) begin
            $display("mismatch: expected ev=%0d line=%0d cl=%h op=%h fv=%b st=%0d cnt=%0d",
                     want.ev, want.line, want.cl, want.op, want.fv, want.st, want.cnt);
            $display("          actual   ev=%0d line=%0d cl=%h op=%h fv=%b st=%0d cnt=%0d",
                     got.ev, got.line, got.cl, got.op, got.fv, got.st, got.cnt);
          end
          bad_results++;
        end
      end
    end
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [7:0] b;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    ch_byte_i = 8'h00;
    last_i = 1'b0;
    out_ready_i = 1'b0;
    bad_results = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    m_mode = MODE_CODE;
    m_pending = 1'b0;
    m_depth = 0;
    m_line = 32'd1;
    m_err = 1'b0;
    m_halted = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (text_rows[i]) begin
      send_byte(text_rows[i].ch, text_rows[i].lst, text_rows[i].typed, text_rows[i].res);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      case (n / 40)
        0, 4: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 54;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 54;
        end
        default: begin
          send_idle_pct = 29;
          recv_stall_pct = 29;
        end
      endcase
      // The receiver holds off long enough for the block to fill and stall its input.
      if (n == 20) hold_left = 400;
      if (n == 140) begin
        in_valid_i <= 1'b0;
        while (scan_results_q.size() != 0) @(posedge clk_i);
      end
      b = pick_text_byte();
      send_byte(b, $urandom_range(99) < 3, 1'b0, NO_RES);
    end

    // Return to plain code, fill the bracket stack to the brim, then overflow it.
    send_idle_pct = 29;
    recv_stall_pct = 29;
    while (m_mode != MODE_CODE || m_pending) begin
      if (m_pending) b = (m_mode == MODE_COMMENT) ? CH_SLASH : 8'h61;
      else if (m_mode == MODE_COMMENT) b = CH_STAR;
      else b = (m_mode == MODE_SQ) ? CH_SQUOTE : CH_DQUOTE;
      send_byte(b, 1'b0, 1'b0, NO_RES);
    end
    while (m_depth < STACK_DEPTH - 1) begin
      send_byte(CH_LPAREN, 1'b0, 1'b0, NO_RES);
    end
    send_byte(CH_LBRACE, 1'b1, 1'b0, NO_RES);
    send_byte(CH_LBRACK, 1'b0, 1'b0, NO_RES);
    for (int n = 0; n < 20; n++) begin
      send_byte(($urandom_range(3) == 0) ? CH_NEWLINE : 8'($urandom),
                1'($urandom_range(1)), 1'b0, NO_RES);
    end
    send_byte(CH_RPAREN, 1'b1, 1'b0, NO_RES);

    in_valid_i <= 1'b0;
    while (scan_results_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (bad_results == 0 && scan_results_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
